@@ src/fcc_pkg.sv @@
// ----------------------------------------------------------------------------
// fcc_pkg: shared types and constants of the cluster chain sector cache
// Field widths, status codes, controller/datapath command and status groups,
// and the FAT entry decode.
// ----------------------------------------------------------------------------
package fcc_pkg;

    localparam int CLUSTER_W        = 28;
    localparam int WORD_W           = 32;
    localparam int SECTOR_W         = 32;
    localparam int STATUS_W         = 2;
    localparam int DEF_CACHE_SLOTS  = 8;
    localparam int DEF_WORDS_PER_SECTOR = 128;

    localparam logic [WORD_W-1:0] ENTRY_MASK   = 32'h0FFF_FFFF;
    localparam logic [WORD_W-1:0] END_OF_CHAIN = 32'h0FFF_FFF8;
    localparam logic [WORD_W-1:0] BAD_CLUSTER  = 32'h0FFF_FFF7;

    localparam logic [STATUS_W-1:0] ST_ANSWER = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_FILL   = 1'b1;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [CLUSTER_W-1:0] next_cluster;
        logic [SECTOR_W-1:0]  fetch_sector;
        logic                 was_hit;
    } t_result;

    // Controller to datapath
    typedef struct packed {
        logic lookup;   // capture lookup, form sector and word index
        logic fill;     // store one fill word
        logic reject;   // stage a rejected-command result
        logic tag;      // compare sector against slot tags
        logic ans;      // decode the read word into an answer
        logic put;      // move staged result into the output register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_fill;     // incoming item is a fill word
        logic awaiting;    // a miss waits for its fill words
        logic fill_last;   // next fill word completes the slot
        logic tag_hit;     // sector found in a valid slot
    } t_dp_stat;

    function automatic logic [CLUSTER_W-1:0] decode_entry(input logic [WORD_W-1:0] word);
        logic [WORD_W-1:0] e;
        e = word & ENTRY_MASK;
        if (e >= END_OF_CHAIN || e == BAD_CLUSTER) begin
            return '0;
        end
        return e[CLUSTER_W-1:0];
    endfunction

endpackage

@@ src/fcc_if.sv @@
// ----------------------------------------------------------------------------
// fcc_if: valid/ready channels of the cluster chain sector cache
// Request, response and configuration channels.
// ----------------------------------------------------------------------------
interface fcc_req_if;
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic [fcc_pkg::CLUSTER_W-1:0] cluster;
    logic [fcc_pkg::WORD_W-1:0]    fill_word;

    modport source (output valid, cmd, cluster, fill_word, input ready);
    modport sink   (input valid, cmd, cluster, fill_word, output ready);
endinterface

interface fcc_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [fcc_pkg::STATUS_W-1:0]  status;
    logic [fcc_pkg::CLUSTER_W-1:0] next_cluster;
    logic [fcc_pkg::SECTOR_W-1:0]  fetch_sector;
    logic                          was_hit;

    modport source (output valid, status, next_cluster, fetch_sector, was_hit, input ready);
    modport sink   (input valid, status, next_cluster, fetch_sector, was_hit, output ready);
endinterface

interface fcc_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [fcc_pkg::SECTOR_W-1:0] fat_base_sector;

    modport source (output valid, fat_base_sector, input ready);
    modport sink   (input valid, fat_base_sector, output ready);
endinterface

@@ src/fcc_ctrl.sv @@
// ----------------------------------------------------------------------------
// fcc_ctrl: sequencer of the cluster chain sector cache
// One-hot state machine that steps a lookup through tag check, memory read,
// decode and result hand-off; the last fill word skips the tag check.
// ----------------------------------------------------------------------------
module fcc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    output logic              o_rsp_valid,
    input  logic              i_rsp_ready,
    input  fcc_pkg::t_dp_stat i_stat,
    output fcc_pkg::t_dp_cmd  o_cmd
);
    import fcc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_TAG  = 5'b00010,
        S_RD   = 5'b00100,
        S_DEC  = 5'b01000,
        S_PUT  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_rsp_ready;
    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_rsp_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    if (!i_stat.is_fill) begin
                        if (i_stat.awaiting) begin
                            o_cmd.reject = 1'b1;
                            n_state      = S_PUT;
                        end else begin
                            o_cmd.lookup = 1'b1;
                            n_state      = S_TAG;
                        end
                    end else if (!i_stat.awaiting) begin
                        o_cmd.reject = 1'b1;
                        n_state      = S_PUT;
                    end else begin
                        o_cmd.fill = 1'b1;
                        if (i_stat.fill_last) begin
                            n_state = S_RD;
                        end
                    end
                end
            end
            S_TAG: begin
                o_cmd.tag = 1'b1;
                n_state   = i_stat.tag_hit ? S_RD : S_PUT;
            end
            S_RD: begin
                n_state = S_DEC;
            end
            S_DEC: begin
                o_cmd.ans = 1'b1;
                n_state   = S_PUT;
            end
            S_PUT: begin
                if (out_free) begin
                    o_cmd.put   = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ src/fcc_datapath.sv @@
// ----------------------------------------------------------------------------
// fcc_datapath: tags, sector store and result registers
// Forms sector and word index, compares tags, writes fill words and reads
// cached FAT entries.
// ----------------------------------------------------------------------------
module fcc_datapath #(
    parameter int CACHE_SLOTS      = fcc_pkg::DEF_CACHE_SLOTS,
    parameter int WORDS_PER_SECTOR = fcc_pkg::DEF_WORDS_PER_SECTOR
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fcc_pkg::t_dp_cmd              i_cmd,
    output fcc_pkg::t_dp_stat             o_stat,
    input  logic                          i_cfg_we,
    input  logic [fcc_pkg::SECTOR_W-1:0]  i_cfg_data,
    input  logic                          i_in_cmd,
    input  logic [fcc_pkg::CLUSTER_W-1:0] i_cluster,
    input  logic [fcc_pkg::WORD_W-1:0]    i_fill_word,
    output fcc_pkg::t_result              o_result
);
    import fcc_pkg::*;

    localparam int IDX_W  = $clog2(WORDS_PER_SECTOR);
    localparam int SLOT_W = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
    localparam int DEPTH  = CACHE_SLOTS * (1 << IDX_W);
    localparam int ADDR_W = SLOT_W + IDX_W;

    logic [SECTOR_W-1:0]    r_base;
    logic [SECTOR_W-1:0]    r_slot_tag [CACHE_SLOTS];
    logic [CACHE_SLOTS-1:0] r_slot_valid;
    logic [SLOT_W-1:0]      r_next_slot;
    logic                   r_awaiting;
    logic [SECTOR_W-1:0]    r_pend_sector;
    logic [IDX_W-1:0]       r_pend_idx;
    logic [IDX_W-1:0]       r_fill_count;
    logic [SECTOR_W-1:0]    r_sector;
    logic [IDX_W-1:0]       r_idx;
    logic [SLOT_W-1:0]      r_rd_slot;
    logic                   r_rd_hit;
    logic [WORD_W-1:0]      r_rd_data;
    logic [WORD_W-1:0]      r_mem [DEPTH];
    t_result                r_res;
    t_result                r_out;

    logic [SECTOR_W-1:0]    in_sector;
    logic [IDX_W-1:0]       in_idx;
    logic                   hit;
    logic [SLOT_W-1:0]      hit_slot;
    logic                   fill_last;
    logic [SLOT_W-1:0]      slot_after;

    assign in_sector = r_base + SECTOR_W'(i_cluster / WORDS_PER_SECTOR);
    assign in_idx    = IDX_W'(i_cluster % WORDS_PER_SECTOR);
    assign fill_last = (r_fill_count == IDX_W'(WORDS_PER_SECTOR - 1));
    assign slot_after = (r_next_slot == SLOT_W'(CACHE_SLOTS - 1)) ? '0 : r_next_slot + 1'b1;

    // Lowest-numbered matching slot wins
    always_comb begin
        hit      = 1'b0;
        hit_slot = '0;
        for (int s = CACHE_SLOTS - 1; s >= 0; s--) begin
            if (r_slot_valid[s] && r_slot_tag[s] == r_sector) begin
                hit      = 1'b1;
                hit_slot = SLOT_W'(s);
            end
        end
    end

    assign o_stat.is_fill   = (i_in_cmd == CMD_FILL);
    assign o_stat.awaiting  = r_awaiting;
    assign o_stat.fill_last = fill_last;
    assign o_stat.tag_hit   = hit;
    assign o_result         = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base       <= '0;
            r_slot_valid <= '0;
            r_next_slot  <= '0;
            r_awaiting   <= 1'b0;
            r_fill_count <= '0;
        end else begin
            if (i_cfg_we) begin
                r_base <= i_cfg_data;
            end
            if (i_cmd.fill) begin
                r_fill_count <= r_fill_count + 1'b1;
                if (fill_last) begin
                    r_fill_count              <= '0;
                    r_slot_valid[r_next_slot] <= 1'b1;
                    r_next_slot               <= slot_after;
                    r_awaiting                <= 1'b0;
                end
            end
            if (i_cmd.tag && !hit) begin
                r_awaiting   <= 1'b1;
                r_fill_count <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_sector <= in_sector;
            r_idx    <= in_idx;
        end
        if (i_cmd.fill && fill_last) begin
            r_slot_tag[r_next_slot] <= r_pend_sector;
            r_rd_slot               <= r_next_slot;
            r_idx                   <= r_pend_idx;
            r_rd_hit                <= 1'b0;
        end
        if (i_cmd.tag) begin
            if (hit) begin
                r_rd_slot <= hit_slot;
                r_rd_hit  <= 1'b1;
            end else begin
                r_pend_sector      <= r_sector;
                r_pend_idx         <= r_idx;
                r_res.status       <= ST_MISS;
                r_res.next_cluster <= '0;
                r_res.fetch_sector <= r_sector;
                r_res.was_hit      <= 1'b0;
            end
        end
        if (i_cmd.reject) begin
            r_res.status       <= ST_REJECT;
            r_res.next_cluster <= '0;
            r_res.fetch_sector <= '0;
            r_res.was_hit      <= 1'b0;
        end
        if (i_cmd.ans) begin
            r_res.status       <= ST_ANSWER;
            r_res.next_cluster <= decode_entry(r_rd_data);
            r_res.fetch_sector <= '0;
            r_res.was_hit      <= r_rd_hit;
        end
        if (i_cmd.put) begin
            r_out <= r_res;
        end
    end

    // Sector store: one write port for fill words, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.fill) begin
            r_mem[ADDR_W'({r_next_slot, r_fill_count})] <= i_fill_word;
        end
        r_rd_data <= r_mem[ADDR_W'({r_rd_slot, r_idx})];
    end

endmodule

@@ src/fat32_chain_entry_sector_cache.sv @@
// ----------------------------------------------------------------------------
// fat32_chain_entry_sector_cache: FAT32 next-cluster lookup with sector cache
// Looks up the FAT entry of a cluster in a small round-robin cache of FAT
// sectors, asks for the sector on a miss and takes its words as fill items.
// ----------------------------------------------------------------------------
//
//  channel  | dir | transfer when         | payload
//  ---------+-----+-----------------------+-----------------------------------------
//  i_req    | in  | valid & ready         | cmd, cluster, fill_word
//  o_rsp    | out | valid & ready         | status, next_cluster, fetch_sector, was_hit
//  i_cfg    | in  | valid & ready (ready=1)| fat_base_sector
//
// Steps: a fill word that does not complete a sector is taken in idle, so a
// sector streams in at one word per cycle. A lookup hit passes tag compare,
// registered read of the sector store, decode and output load; the last fill
// word skips the tag compare; a miss goes from tag compare to output load,
// and a rejected command goes straight to output load.
// Reset: synchronous, active low; it clears all slot valid bits, the base
// sector, the fill state and the output valid. Tags and store need none.
// Stalls: a result waits in the output register; the block takes a new
// request while it waits, and holds the next result until it is taken.
module fat32_chain_entry_sector_cache #(
    parameter int CACHE_SLOTS      = fcc_pkg::DEF_CACHE_SLOTS,
    parameter int WORDS_PER_SECTOR = fcc_pkg::DEF_WORDS_PER_SECTOR
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fcc_req_if.sink   i_req,
    fcc_rsp_if.source o_rsp,
    fcc_cfg_if.sink   i_cfg
);
    import fcc_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;
    t_result  result;

    // Configuration is written only while idle: a rule for the user that the block does not enforce; always take it
    assign i_cfg.ready = 1'b1;

    fcc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    fcc_datapath #(
        .CACHE_SLOTS      (CACHE_SLOTS),
        .WORDS_PER_SECTOR (WORDS_PER_SECTOR)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_data  (i_cfg.fat_base_sector),
        .i_in_cmd    (i_req.cmd),
        .i_cluster   (i_req.cluster),
        .i_fill_word (i_req.fill_word),
        .o_result    (result)
    );

    // Drive the response payload from the output register
    assign o_rsp.status       = result.status;
    assign o_rsp.next_cluster = result.next_cluster;
    assign o_rsp.fetch_sector = result.fetch_sector;
    assign o_rsp.was_hit      = result.was_hit;

endmodule
